### design/assert_macros.svh
// Assertion macros used by the port checker of the scan driver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define SSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/sss_pkg.sv
// Shared constants, types and the segment decode table of the scan driver.
package sss_pkg;

    localparam int MAX_DIGITS_DEF   = 8;
    localparam int SEGS_PER_DIGIT   = 7;
    localparam int VALUE_W          = 32;

    // Reciprocal of ten for a 32-bit dividend: q = (v * RECIP) >> RECIP_SHIFT
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // Configuration register map
    localparam int          CFG_ADDR_W        = 3;
    localparam logic        REG_DIGITS_IN_USE = 1'b0;
    localparam logic [3:0]  DIGITS_RESET      = 4'd4;

    // Input kind codes
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // Load sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_WB   = 3'b100
    } seq_state_t;

    // Store write request from the sequencer
    typedef struct packed {
        logic       en;
        logic [6:0] segs;
    } seg_wr_t;

    // Standard a..g decode, segment a in bit 0
    function automatic logic [6:0] seg_decode(input logic [3:0] dig);
        logic [6:0] segs;
        begin
            unique case (dig)
                4'd0:    segs = 7'h3f;
                4'd1:    segs = 7'h06;
                4'd2:    segs = 7'h5b;
                4'd3:    segs = 7'h4f;
                4'd4:    segs = 7'h66;
                4'd5:    segs = 7'h6d;
                4'd6:    segs = 7'h7d;
                4'd7:    segs = 7'h07;
                4'd8:    segs = 7'h7f;
                4'd9:    segs = 7'h67;
                default: segs = 7'h00;
            endcase
            return segs;
        end
    endfunction

endpackage

### design/sss_div10.sv
// Shared divide-by-ten unit: registered reciprocal product, then quotient and remainder.
module sss_div10
(
    input  logic                               clk,
    input  logic                               mul_en,
    input  logic [sss_pkg::VALUE_W-1:0]        dividend,
    output logic [sss_pkg::VALUE_W-1:0]        quot,
    output logic [3:0]                         rem
);

    logic [2*sss_pkg::VALUE_W-1:0] prod_reg;
    logic [2*sss_pkg::VALUE_W-1:0] prod_next;
    logic [sss_pkg::VALUE_W-1:0]   dvd_reg;
    logic [sss_pkg::VALUE_W-1:0]   dvd_next;
    logic [sss_pkg::VALUE_W-1:0]   times_ten;

    // Product stage
    always_comb
    begin
        prod_next = prod_reg;
        dvd_next  = dvd_reg;
        if (mul_en)
        begin
            prod_next = dividend * sss_pkg::RECIP_TEN;
            dvd_next  = dividend;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        dvd_reg  <= dvd_next;
    end

    // Quotient from the top bits, remainder by shift-add back-multiply
    always_comb
    begin
        quot      = sss_pkg::VALUE_W'(prod_reg[2*sss_pkg::VALUE_W-1:sss_pkg::RECIP_SHIFT]);
        times_ten = (quot << 3) + (quot << 1);
        rem       = 4'(dvd_reg - times_ten);
    end

endmodule

### design/sss_seg_store.sv
// Segment bit store: one 7-bit row per digit, cleared by reset.
module sss_seg_store
#(
    parameter int MAX_DIGITS = sss_pkg::MAX_DIGITS_DEF,
    parameter int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  sss_pkg::seg_wr_t   wr,
    input  logic [IDX_W-1:0]   wr_row,
    input  logic               rd_en,
    input  logic [IDX_W-1:0]   rd_row,
    input  logic [2:0]         rd_seg,
    output logic               rd_bit
);

    logic [sss_pkg::SEGS_PER_DIGIT-1:0] rows_reg [MAX_DIGITS];
    logic                               rd_bit_reg;

    // Row write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                rows_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            rows_reg[wr_row] <= wr.segs;
        end
    end

    // Registered bit read at the scan position
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_bit_reg <= rows_reg[rd_row][rd_seg];
        end
    end

    assign rd_bit = rd_bit_reg;

endmodule

### design/seven_segment_scan_driver_core.sv
// Top level of the seven-segment scan driver: config, load sequencer, scan counter, output.
//
//  channel  | dir | fields
//  ---------+-----+-----------------------------------------------------------
//  s_*      | in  | tuser: kind; tdata: value[31:0]
//  m_*      | out | tdata: digit_index[2:0], segment_index[5:3], lit[6], 0[7]
//  p*       | in  | APB register port, digits_in_use at byte address 0
//
// A tick's result is registered at the accepting edge.
// A load handles D digits, D the clamped digit count: for each digit the divide unit
// forms the reciprocal product in ST_MUL, then ST_WB writes the remainder's row.
// s_tready is low during a load and while an undelivered result is stalled.
// Reset clears the segment store, the scan position and digits_in_use to 4.
module seven_segment_scan_driver_core
#(
    parameter int MAX_DIGITS = sss_pkg::MAX_DIGITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,  // [31:0] value
    input  logic                              s_tuser,  // [0] kind
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,  // [2:0] digit_index,
                                                        // [5:3] segment_index,
                                                        // [6] lit, [7] zero
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sss_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int EXT_W = IDX_W + 3;

    sss_pkg::seq_state_t          state_reg, state_next;
    logic [3:0]                   digits_reg, digits_next;
    logic [sss_pkg::VALUE_W-1:0]  val_reg, val_next;
    logic [IDX_W-1:0]             ld_row_reg, ld_row_next;
    logic [IDX_W-1:0]             dig_reg, dig_next;
    logic [2:0]                   seg_reg, seg_next;
    logic                         out_valid_reg, out_valid_next;
    logic [5:0]                   out_data_reg, out_data_next;

    logic [4:0]                   digits_clamp;
    logic [CNT_W-1:0]             digits_act;
    logic [CNT_W-1:0]             dig_step;
    logic [2:0]                   seg_step;
    logic [EXT_W-1:0]             dig_ext;
    logic [sss_pkg::VALUE_W-1:0]  quot;
    logic [3:0]                   rem;
    logic                         lit_bit;
    logic                         accept;
    logic                         rd_en;
    logic                         cfg_wr;
    sss_pkg::seg_wr_t             wr;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == sss_pkg::REG_DIGITS_IN_USE);
    assign prdata = (paddr[2] == sss_pkg::REG_DIGITS_IN_USE) ? {28'd0, digits_reg} : 32'd0;

    always_comb
    begin
        digits_next = digits_reg;
        if (cfg_wr)
        begin
            digits_next = pwdata[3:0];
        end
    end

    // Clamp digit count to 1..MAX_DIGITS
    always_comb
    begin
        priority if (digits_reg == 4'd0)
        begin
            digits_clamp = 5'd1;
        end
        else if ({1'b0, digits_reg} > 5'(MAX_DIGITS))
        begin
            digits_clamp = 5'(MAX_DIGITS);
        end
        else
        begin
            digits_clamp = {1'b0, digits_reg};
        end
        digits_act = CNT_W'(digits_clamp);
    end

    // Handshake
    assign s_tready = (state_reg == sss_pkg::ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign rd_en    = accept && (s_tuser == sss_pkg::KIND_TICK);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, lit_bit, out_data_reg};

    // Shared divide-by-ten unit
    sss_div10 u_div
    (
        .clk      (clk),
        .mul_en   (state_reg == sss_pkg::ST_MUL),
        .dividend (val_reg),
        .quot     (quot),
        .rem      (rem)
    );

    // Segment store
    assign wr.en   = (state_reg == sss_pkg::ST_WB);
    assign wr.segs = sss_pkg::seg_decode(rem);

    // Next scan position, wrapping at the scan length
    always_comb
    begin
        if (seg_reg == 3'(sss_pkg::SEGS_PER_DIGIT - 1))
        begin
            seg_step = 3'd0;
            dig_step = {1'b0, dig_reg} + CNT_W'(1);
        end
        else
        begin
            seg_step = seg_reg + 3'd1;
            dig_step = {1'b0, dig_reg};
        end
        if (dig_step >= digits_act)
        begin
            seg_step = 3'd0;
            dig_step = '0;
        end
        dig_ext = EXT_W'(dig_step[IDX_W-1:0]);
    end

    // Lit bit is read into the store's output register on a tick request
    sss_seg_store #(
        .MAX_DIGITS (MAX_DIGITS),
        .IDX_W      (IDX_W)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .wr_row (ld_row_reg),
        .rd_en  (rd_en),
        .rd_row (dig_step[IDX_W-1:0]),
        .rd_seg (seg_step),
        .rd_bit (lit_bit)
    );

    // Load sequencer, scan counter and output register
    always_comb
    begin
        state_next     = state_reg;
        val_next       = val_reg;
        ld_row_next    = ld_row_reg;
        dig_next       = dig_reg;
        seg_next       = seg_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            sss_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == sss_pkg::KIND_LOAD)
                    begin
                        val_next    = s_tdata;
                        ld_row_next = '0;
                        state_next  = sss_pkg::ST_MUL;
                    end
                    else
                    begin
                        dig_next       = dig_step[IDX_W-1:0];
                        seg_next       = seg_step;
                        out_valid_next = 1'b1;
                        out_data_next  = {seg_step, dig_ext[2:0]};
                    end
                end
            end
            sss_pkg::ST_MUL:
            begin
                state_next = sss_pkg::ST_WB;
            end
            sss_pkg::ST_WB:
            begin
                val_next    = quot;
                ld_row_next = ld_row_reg + IDX_W'(1);
                if (({1'b0, ld_row_reg} + CNT_W'(1)) == digits_act)
                begin
                    state_next = sss_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = sss_pkg::ST_MUL;
                end
            end
            default:
            begin
                state_next = sss_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sss_pkg::ST_IDLE;
            digits_reg    <= sss_pkg::DIGITS_RESET;
            dig_reg       <= '0;
            seg_reg       <= 3'd0;
            ld_row_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            digits_reg    <= digits_next;
            dig_reg       <= dig_next;
            seg_reg       <= seg_next;
            ld_row_reg    <= ld_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        out_data_reg <= out_data_next;
    end

endmodule

### design/sss_port_checker.sv
// Port-level checker of the scan driver, bound to the top level.
`include "assert_macros.svh"

module sss_port_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    logic out_stall;
    logic load_acc;
    logic tick_acc;

    // Handshake terms
    assign out_stall = m_tvalid && !m_tready;
    assign load_acc  = s_tvalid && s_tready && (s_tuser == sss_pkg::KIND_LOAD);
    assign tick_acc  = s_tvalid && s_tready && (s_tuser == sss_pkg::KIND_TICK);

    // Stalled result holds
    `SSS_ASSERT(a_out_hold, out_stall |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

    // Segment index stays within a..g
    `SSS_ASSERT(a_seg_range, m_tvalid |-> (m_tdata[5:3] != 3'd7), "segment index out of range")

    // A load keeps the input side busy on the next cycle
    `SSS_ASSERT(a_load_busy, load_acc |=> !s_tready, "ready right after a load")

    // A tick gives a result on the next cycle
    `SSS_ASSERT(a_tick_result, tick_acc |=> m_tvalid, "tick without result")

endmodule

bind seven_segment_scan_driver_core sss_port_checker u_port_checker (.*);

### verif/testbench.sv
// Self-checking testbench for the seven-segment scan driver core.
`timescale 1ns / 1ps

module testbench;

    localparam int STORE_BITS      = sss_pkg::MAX_DIGITS_DEF * sss_pkg::SEGS_PER_DIGIT;
    localparam int SPARE_REG_INDEX = 1;
    localparam int RANDOM_PHASES   = 10;
    localparam int PHASE_ITEMS     = 75;
    localparam int SETTLE_CYCLES   = 40;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int REPORT_LIMIT    = 10;

    // a..g glyphs for decimal digits, segment a in bit 0
    localparam logic [6:0] DIGIT_GLYPH [10] = '{
        7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h67
    };

    // one scan result as it sits in m_tdata, lowest field last
    typedef struct packed {
        logic       pad;
        logic       lit;
        logic [2:0] segment;
        logic [2:0] digit;
    } scan_result_t;

    // Tracks display contents and scan position; holds the expected scan results
    class scan_scoreboard;
        logic [3:0]            digit_setting;
        logic [STORE_BITS-1:0] lit_map;
        int unsigned           scan_pos;
        scan_result_t          expected_scans[$];
        int unsigned           mismatches;

        function new();
            digit_setting = sss_pkg::DIGITS_RESET;
            lit_map       = '0;
            scan_pos      = 0;
            mismatches    = 0;
        endfunction

        function int unsigned outstanding();
            return expected_scans.size();
        endfunction

        function int unsigned live_digits();
            int unsigned d;
            d = digit_setting;
            if (d < 1)
                d = 1;
            if (d > sss_pkg::MAX_DIGITS_DEF)
                d = sss_pkg::MAX_DIGITS_DEF;
            return d;
        endfunction

        function void write_register(int unsigned index, logic [31:0] data);
            if (index == int'(sss_pkg::REG_DIGITS_IN_USE))
                digit_setting = data[3:0];
        endfunction

        // accepted request: a load rewrites the store, a tick yields one scan result
        function void note_request(logic kind, logic [31:0] value);
            int unsigned  digits;
            logic [31:0]  rest;
            logic [6:0]   glyph;
            scan_result_t res;
            digits = live_digits();
            if (kind == sss_pkg::KIND_LOAD)
            begin
                rest = value;
                for (int d = 0; d < digits; d++)
                begin
                    glyph = DIGIT_GLYPH[4'(rest % 10)];
                    for (int s = 0; s < sss_pkg::SEGS_PER_DIGIT; s++)
                        lit_map[d * sss_pkg::SEGS_PER_DIGIT + s] = glyph[s];
                    rest = rest / 10;
                end
            end
            else
            begin
                scan_pos = scan_pos + 1;
                // also catches a position left beyond a shrunken scan length
                if (scan_pos >= digits * sss_pkg::SEGS_PER_DIGIT)
                    scan_pos = 0;
                res.pad     = 1'b0;
                res.digit   = 3'((scan_pos / sss_pkg::SEGS_PER_DIGIT) & 7);
                res.segment = 3'(scan_pos % sss_pkg::SEGS_PER_DIGIT);
                res.lit     = (scan_pos < STORE_BITS) ? lit_map[scan_pos] : 1'b0;
                expected_scans.push_back(res);
            end
        endfunction

        function void check_result(logic [7:0] tdata);
            scan_result_t got;
            scan_result_t want;
            got = tdata;
            if (expected_scans.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] unexpected scan result %h", $time, tdata);
                return;
            end
            want = expected_scans.pop_front();
            if (got.digit !== want.digit || got.segment !== want.segment ||
                got.lit !== want.lit || got.pad !== want.pad)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"[%0t] scan mismatch: digit %0d/%0d segment %0d/%0d",
                              " lit %b/%b pad %b/%b (exp/act)"},
                             $time, want.digit, got.digit, want.segment, got.segment,
                             want.lit, got.lit, want.pad, got.pad);
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] value
    logic        s_tuser  = 1'b0; // [0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [2:0] digit_index, [5:3] segment_index, [6] lit, [7] zero
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [sss_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int unsigned tx_idle_pct = 18;
    int unsigned rx_idle_pct = 18;
    int unsigned cycle_count = 0;

    scan_scoreboard sb = new();

    seven_segment_scan_driver_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // handshake monitor: register writes, requests and results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
                sb.write_register(paddr >> 2, pwdata);
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    task automatic send_request(input logic kind, input logic [31:0] value);
        int unsigned gap;
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_ticks(input int unsigned count);
        repeat (count) send_request(sss_pkg::KIND_TICK, $urandom());
    endtask

    task automatic apb_write(input int unsigned index, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= sss_pkg::CFG_ADDR_W'(index * 4);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop sending, wait for every scan result, then let a load in flight finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_digits(input logic [3:0] code);
        apb_write(sss_pkg::REG_DIGITS_IN_USE, {28'($urandom_range(0, 32'h0fff_ffff)), code});
    endtask

    function automatic logic [31:0] pick_value();
        unique case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 9);
            1:       return $urandom_range(0, 99999999);
            2:       return 32'hffff_ffff - $urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("seven_segment_scan_driver_core regression: fail");
        $finish;
    end

    initial
    begin
        int unsigned load_pct;
        logic [3:0]  code;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, largest value, clamped digit counts, shrink wrap
        send_request(sss_pkg::KIND_TICK, 32'h0);
        send_request(sss_pkg::KIND_LOAD, 32'hffff_ffff);
        send_ticks(10);
        wait_idle();
        set_digits(4'd0);
        send_ticks(1);
        send_request(sss_pkg::KIND_LOAD, 32'd8);
        send_ticks(2);
        wait_idle();
        set_digits(4'd15);
        send_request(sss_pkg::KIND_LOAD, 32'd0);
        send_request(sss_pkg::KIND_LOAD, 32'd1234567890);
        send_ticks(2);
        wait_idle();
        apb_write(SPARE_REG_INDEX, 32'hffff_ffff);
        send_ticks(2);

        // random phases over several digit counts, extremes first
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            unique case (phase)
                0:       code = 4'd1;
                1:       code = 4'd8;
                2:       code = 4'd0;
                3:       code = 4'd15;
                default: code = 4'($urandom_range(0, 15));
            endcase
            set_digits(code);
            if ($urandom_range(0, 1) == 1)
                apb_write(SPARE_REG_INDEX, $urandom());
            // two phases run with no idling on either side
            tx_idle_pct = (phase == 4 || phase == 5) ? 0 : 18;
            rx_idle_pct = tx_idle_pct;
            load_pct    = $urandom_range(15, 40);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < load_pct)
                    send_request(sss_pkg::KIND_LOAD, pick_value());
                else
                    send_request(sss_pkg::KIND_TICK, $urandom());
            end
        end

        wait_idle();
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("seven_segment_scan_driver_core regression: pass");
        else
            $display("seven_segment_scan_driver_core regression: fail");
        $finish;
    end

endmodule
